FILE: rtl/core/glyph_outline_decoder_core_assert.svh
// Assertion macros used by the checker of the glyph outline decoder.
// Both sample on the rising edge of clk and are disabled while rst is high.
`ifndef GLYPH_OUTLINE_DECODER_CORE_ASSERT_SVH
`define GLYPH_OUTLINE_DECODER_CORE_ASSERT_SVH

// Same-cycle implication.
`define GDEC_CHECK(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define GDEC_CHECK_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/core/gdec_pkg.sv
package gdec_pkg;

  typedef enum logic [3:0] {
    PH_SWEEP,
    PH_IDLE,
    PH_HEAD,
    PH_ENDS,
    PH_ILEN,
    PH_HINT,
    PH_FLAG,
    PH_REP,
    PH_FILL,
    PH_PRIME,
    PH_SETTLE,
    PH_COORD,
    PH_READ
  } gdec_phase_t;

  typedef enum logic [1:0] {
    CMD_FIRST = 2'd0,
    CMD_NEXT  = 2'd1,
    CMD_READ  = 2'd2,
    CMD_NONE  = 2'd3
  } gdec_cmd_t;

  localparam logic [2:0] ST_POINT     = 3'd0;
  localparam logic [2:0] ST_DONE      = 3'd1;
  localparam logic [2:0] ST_COMPOSITE = 3'd2;
  localparam logic [2:0] ST_TOOMANY   = 3'd3;
  localparam logic [2:0] ST_TRUNC     = 3'd4;
  localparam logic [2:0] ST_NOPOINT   = 3'd5;

  localparam int COORD_W = 27;
  localparam int FLAG_W  = 5;
  localparam int EPOCH_W = 8;

  // Bit positions inside a packed (5-bit) flag.
  localparam int F_ON    = 0;
  localparam int F_XS    = 1;
  localparam int F_YS    = 2;
  localparam int F_XSAME = 3;
  localparam int F_YSAME = 4;

  // Repeat bit inside a raw flag byte.
  localparam int B_REPEAT = 3;

  localparam logic [15:0] HEAD_BYTES  = 16'd10;
  localparam logic [16:0] POINT_LIMIT = 17'd10000;

  typedef struct packed {
    logic flag_we;
    logic x_we;
    logic y_we;
    logic end_we;
  } gdec_wr_t;

  // Keep on-curve, both short bits and both same bits.
  function automatic logic [FLAG_W-1:0] pack_flag(input logic [7:0] b);
    return {b[5], b[4], b[2], b[1], b[0]};
  endfunction

endpackage

FILE: rtl/core/gdec_mem.sv
module gdec_mem import gdec_pkg::*; #(
  parameter int MAX_POINTS = 1024
) (
  input  logic                         clk,
  input  gdec_wr_t                     wr,
  input  logic [$clog2(MAX_POINTS)-1:0] waddr,
  input  logic [FLAG_W-1:0]            flag_wdata,
  input  logic [COORD_W-1:0]           coord_wdata,
  input  logic [EPOCH_W-1:0]           end_wdata,
  input  logic [$clog2(MAX_POINTS)-1:0] rd_addr,
  output logic [FLAG_W-1:0]            flag_rd,
  output logic [COORD_W-1:0]           x_rd,
  output logic [COORD_W-1:0]           y_rd,
  output logic [EPOCH_W-1:0]           end_rd
);

  logic [FLAG_W-1:0]  flag_mem [MAX_POINTS];
  logic [COORD_W-1:0] x_mem    [MAX_POINTS];
  logic [COORD_W-1:0] y_mem    [MAX_POINTS];
  logic [EPOCH_W-1:0] end_mem  [MAX_POINTS];

  always_ff @(posedge clk) begin
    if (wr.flag_we) flag_mem[waddr] <= flag_wdata;
    if (wr.x_we)    x_mem[waddr]    <= coord_wdata;
    if (wr.y_we)    y_mem[waddr]    <= coord_wdata;
    if (wr.end_we)  end_mem[waddr]  <= end_wdata;
  end

  always_ff @(posedge clk) begin
    flag_rd <= flag_mem[rd_addr];
    x_rd    <= x_mem[rd_addr];
    y_rd    <= y_mem[rd_addr];
    end_rd  <= end_mem[rd_addr];
  end

endmodule

FILE: rtl/core/gdec_ctrl.sv
module gdec_ctrl import gdec_pkg::*; #(
  parameter int MAX_POINTS = 1024
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [1:0]                    cmd,
  input  logic [7:0]                    glyph_byte,
  input  logic [9:0]                    point_index,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [2:0]                    status,
  output logic signed [COORD_W-1:0]     point_x,
  output logic signed [COORD_W-1:0]     point_y,
  output logic                          curve_on,
  output logic                          ends_contour,
  output logic [10:0]                   point_count,
  output gdec_wr_t                      wr,
  output logic [$clog2(MAX_POINTS)-1:0] waddr,
  output logic [FLAG_W-1:0]             flag_wdata,
  output logic [COORD_W-1:0]            coord_wdata,
  output logic [EPOCH_W-1:0]            end_wdata,
  output logic [$clog2(MAX_POINTS)-1:0] rd_addr,
  input  logic [FLAG_W-1:0]             flag_rd,
  input  logic [COORD_W-1:0]            x_rd,
  input  logic [COORD_W-1:0]            y_rd,
  input  logic [EPOCH_W-1:0]            end_rd
);

  localparam int AW = $clog2(MAX_POINTS);
  localparam int CW = AW + 1;

  gdec_phase_t        phase, phase_next;
  logic [15:0]        byte_cnt, byte_cnt_next;
  logic [15:0]        contours, contours_next;
  logic [15:0]        last_end, last_end_next;
  logic [7:0]         held, held_next;
  logic [FLAG_W-1:0]  cur_flag, cur_flag_next;
  logic [7:0]         rep_left, rep_left_next;
  logic [CW-1:0]      cursor, cursor_next;
  logic [CW-1:0]      total, total_next;
  logic [COORD_W-1:0] running, running_next;
  logic               axis_y, axis_y_next;
  logic               glyph_ready, glyph_ready_next;
  logic [EPOCH_W-1:0] epoch, epoch_next;
  logic [AW-1:0]      sweep_addr, sweep_addr_next;
  logic               sweep_to_head, sweep_to_head_next;

  logic               out_load;
  logic [2:0]         res_status;
  logic [COORD_W-1:0] res_x, res_y;
  logic               res_on, res_end;
  logic [10:0]        res_cnt;

  logic               take_ok, acc;

  assign take_ok  = phase inside {PH_IDLE, PH_HEAD, PH_ENDS, PH_ILEN, PH_HINT,
                                  PH_FLAG, PH_REP, PH_COORD};
  assign in_stall = !take_ok || (out_valid && out_stall);
  assign acc      = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_SWEEP;
      byte_cnt      <= '0;
      contours      <= '0;
      last_end      <= '0;
      held          <= '0;
      cur_flag      <= '0;
      rep_left      <= '0;
      cursor        <= '0;
      total         <= '0;
      running       <= '0;
      axis_y        <= 1'b0;
      glyph_ready   <= 1'b0;
      epoch         <= '0;
      sweep_addr    <= '0;
      sweep_to_head <= 1'b0;
      out_valid     <= 1'b0;
    end else begin
      phase         <= phase_next;
      byte_cnt      <= byte_cnt_next;
      contours      <= contours_next;
      last_end      <= last_end_next;
      held          <= held_next;
      cur_flag      <= cur_flag_next;
      rep_left      <= rep_left_next;
      cursor        <= cursor_next;
      total         <= total_next;
      running       <= running_next;
      axis_y        <= axis_y_next;
      glyph_ready   <= glyph_ready_next;
      epoch         <= epoch_next;
      sweep_addr    <= sweep_addr_next;
      sweep_to_head <= sweep_to_head_next;
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      status       <= res_status;
      point_x      <= res_x;
      point_y      <= res_y;
      curve_on     <= res_on;
      ends_contour <= res_end;
      point_count  <= res_cnt;
    end
  end

  always_comb begin
    logic [15:0]        word;
    logic [16:0]        n_pts;
    logic [COORD_W-1:0] delta;
    logic [CW-1:0]      cur_inc;
    logic               start_coords;
    logic               sh, sm, take_delta;

    word         = {held, glyph_byte};
    n_pts        = {1'b0, last_end} + 17'd1;
    cur_inc      = cursor + CW'(1);
    delta        = '0;
    start_coords = 1'b0;
    take_delta   = 1'b0;
    sh           = axis_y ? cur_flag[F_YS] : cur_flag[F_XS];
    sm           = axis_y ? cur_flag[F_YSAME] : cur_flag[F_XSAME];

    phase_next         = phase;
    byte_cnt_next      = byte_cnt;
    contours_next      = contours;
    last_end_next      = last_end;
    held_next          = held;
    cur_flag_next      = cur_flag;
    rep_left_next      = rep_left;
    cursor_next        = cursor;
    total_next         = total;
    running_next       = running;
    axis_y_next        = axis_y;
    glyph_ready_next   = glyph_ready;
    epoch_next         = epoch;
    sweep_addr_next    = sweep_addr;
    sweep_to_head_next = sweep_to_head;

    out_load   = 1'b0;
    res_status = ST_POINT;
    res_x      = '0;
    res_y      = '0;
    res_on     = 1'b0;
    res_end    = 1'b0;
    res_cnt    = '0;

    wr          = '0;
    waddr       = cursor[AW-1:0];
    flag_wdata  = pack_flag(glyph_byte);
    coord_wdata = running;
    end_wdata   = epoch;
    rd_addr     = cursor[AW-1:0];

    case (phase)
      PH_SWEEP: begin
        wr.end_we       = 1'b1;
        waddr           = sweep_addr;
        end_wdata       = '0;
        sweep_addr_next = sweep_addr + AW'(1);
        if (sweep_addr == AW'(MAX_POINTS - 1)) begin
          phase_next = sweep_to_head ? PH_HEAD : PH_IDLE;
        end
      end
      PH_READ: begin
        out_load   = 1'b1;
        res_status = ST_POINT;
        res_x      = x_rd;
        res_y      = y_rd;
        res_on     = flag_rd[F_ON];
        res_end    = (end_rd == epoch);
        res_cnt    = 11'(total);
        phase_next = PH_IDLE;
      end
      PH_PRIME: begin
        phase_next = PH_SETTLE;
      end
      PH_SETTLE: begin
        if (cursor >= total) begin
          if (axis_y) begin
            glyph_ready_next = 1'b1;
            out_load         = 1'b1;
            res_status       = ST_DONE;
            res_cnt          = 11'(total);
            phase_next       = PH_IDLE;
          end else begin
            axis_y_next   = 1'b1;
            cursor_next   = '0;
            running_next  = '0;
            byte_cnt_next = '0;
            phase_next    = PH_PRIME;
          end
        end else if ((axis_y ? flag_rd[F_YS] : flag_rd[F_XS]) ||
                     !(axis_y ? flag_rd[F_YSAME] : flag_rd[F_XSAME])) begin
          cur_flag_next = flag_rd;
          phase_next    = PH_COORD;
        end else begin
          // Unchanged coordinate: store it and look at the next flag now.
          wr.x_we     = !axis_y;
          wr.y_we     = axis_y;
          cursor_next = cur_inc;
          rd_addr     = cur_inc[AW-1:0];
        end
      end
      PH_FILL: begin
        wr.flag_we    = 1'b1;
        flag_wdata    = cur_flag;
        cursor_next   = cur_inc;
        rep_left_next = rep_left - 8'd1;
        if (rep_left == 8'd1 || cur_inc >= total) begin
          if (cur_inc < total) begin
            phase_next = PH_FLAG;
          end else begin
            start_coords = 1'b1;
          end
        end
      end
      default: begin
        if (acc) begin
          case (gdec_cmd_t'(cmd))
            CMD_READ: begin
              if (phase != PH_IDLE) begin
                glyph_ready_next = 1'b0;
                out_load         = 1'b1;
                res_status       = ST_TRUNC;
                phase_next       = PH_IDLE;
              end else if (!glyph_ready) begin
                out_load   = 1'b1;
                res_status = ST_NOPOINT;
              end else if (32'(point_index) >= 32'(total)) begin
                out_load   = 1'b1;
                res_status = ST_NOPOINT;
                res_cnt    = 11'(total);
              end else begin
                rd_addr    = AW'(point_index);
                phase_next = PH_READ;
              end
            end
            CMD_FIRST: begin
              glyph_ready_next = 1'b0;
              total_next       = '0;
              held_next        = glyph_byte;
              byte_cnt_next    = 16'd1;
              if (phase != PH_IDLE) begin
                out_load   = 1'b1;
                res_status = ST_TRUNC;
              end
              // New epoch retires all old end marks; clear on wrap.
              if (epoch == '1) begin
                epoch_next         = EPOCH_W'(1);
                sweep_addr_next    = '0;
                sweep_to_head_next = 1'b1;
                phase_next         = PH_SWEEP;
              end else begin
                epoch_next = epoch + EPOCH_W'(1);
                phase_next = PH_HEAD;
              end
            end
            CMD_NEXT: begin
              case (phase)
                PH_HEAD: begin
                  if (byte_cnt == 16'd1) contours_next = word;
                  byte_cnt_next = byte_cnt + 16'd1;
                  if (byte_cnt + 16'd1 >= HEAD_BYTES) begin
                    byte_cnt_next = '0;
                    if (contours_next[15]) begin
                      out_load   = 1'b1;
                      res_status = ST_COMPOSITE;
                      phase_next = PH_IDLE;
                    end else if (contours_next == 16'd0) begin
                      glyph_ready_next = 1'b1;
                      total_next       = '0;
                      out_load         = 1'b1;
                      res_status       = ST_DONE;
                      phase_next       = PH_IDLE;
                    end else begin
                      phase_next = PH_ENDS;
                    end
                  end
                end
                PH_ENDS: begin
                  if (byte_cnt == 16'd0) begin
                    held_next     = glyph_byte;
                    byte_cnt_next = 16'd1;
                  end else begin
                    byte_cnt_next = '0;
                    last_end_next = word;
                    if (32'(word) < MAX_POINTS) begin
                      wr.end_we = 1'b1;
                      waddr     = AW'(word);
                    end
                    contours_next = contours - 16'd1;
                    if (contours == 16'd1) phase_next = PH_ILEN;
                  end
                end
                PH_ILEN: begin
                  if (byte_cnt == 16'd0) begin
                    held_next     = glyph_byte;
                    byte_cnt_next = 16'd1;
                  end else if (n_pts > POINT_LIMIT || 32'(n_pts) > MAX_POINTS) begin
                    out_load   = 1'b1;
                    res_status = ST_TOOMANY;
                    phase_next = PH_IDLE;
                  end else begin
                    total_next    = CW'(n_pts);
                    byte_cnt_next = word;
                    cursor_next   = '0;
                    phase_next    = (word == 16'd0) ? PH_FLAG : PH_HINT;
                  end
                end
                PH_HINT: begin
                  byte_cnt_next = byte_cnt - 16'd1;
                  if (byte_cnt == 16'd1) phase_next = PH_FLAG;
                end
                PH_FLAG: begin
                  wr.flag_we  = 1'b1;
                  cursor_next = cur_inc;
                  if (glyph_byte[B_REPEAT]) begin
                    cur_flag_next = pack_flag(glyph_byte);
                    phase_next    = PH_REP;
                  end else if (cur_inc >= total) begin
                    start_coords = 1'b1;
                  end
                end
                PH_REP: begin
                  if (glyph_byte == 8'd0 || cursor >= total) begin
                    if (cursor < total) begin
                      phase_next = PH_FLAG;
                    end else begin
                      start_coords = 1'b1;
                    end
                  end else begin
                    rep_left_next = glyph_byte;
                    phase_next    = PH_FILL;
                  end
                end
                PH_COORD: begin
                  if (sh) begin
                    delta      = sm ? COORD_W'(glyph_byte) : (COORD_W'(0) - COORD_W'(glyph_byte));
                    take_delta = 1'b1;
                  end else if (byte_cnt == 16'd0) begin
                    held_next     = glyph_byte;
                    byte_cnt_next = 16'd1;
                  end else begin
                    byte_cnt_next = '0;
                    delta         = {{(COORD_W-16){word[15]}}, word};
                    take_delta    = 1'b1;
                  end
                  if (take_delta) begin
                    running_next = running + delta;
                    coord_wdata  = running + delta;
                    wr.x_we      = !axis_y;
                    wr.y_we      = axis_y;
                    cursor_next  = cur_inc;
                    phase_next   = PH_PRIME;
                  end
                end
                default: begin
                  // Stray byte with no open record: drop it.
                end
              endcase
            end
            default: begin
            end
          endcase
        end
      end
    endcase

    if (start_coords) begin
      axis_y_next   = 1'b0;
      cursor_next   = '0;
      running_next  = '0;
      byte_cnt_next = '0;
      phase_next    = PH_PRIME;
    end
  end

endmodule

FILE: rtl/core/glyph_outline_decoder_core.sv
// Simple-glyph outline decoder. Feed one glyph record as items: cmd 0 with
// the first byte, cmd 1 with each following byte; the block parses the
// contour count, end indices, hinting length, run-length flags and X/Y
// deltas into on-chip point memories, and answers with one closing item
// (done, composite, too many points) when the record ends. A cmd 0 or
// cmd 2 while a record is open answers "truncated" and abandons it. Once
// a glyph is done, cmd 2 reads point point_index and returns its
// coordinates, on-curve bit, contour-end mark and the point count.
// A repeat count of n adds up to n flag writes (one per point, clamped to
// the points left). In the coordinate phases every point that carries
// bytes takes its bytes, a write, then a flag-memory read of the next
// point; every unchanged point is stored without bytes, and the start of
// each axis adds a flag-memory read of its first point. A read is the
// registered memory read, then the output load. Contour-end marks are
// tagged with an 8-bit glyph epoch; a clearing pass over all MAX_POINTS
// marks runs after reset, then on the 256th glyph start and on every 255th
// one after it, during which no item is taken. An item is taken only when
// the output register is free or is being emptied on that same edge.
module glyph_outline_decoder_core import gdec_pkg::*; #(
  parameter int MAX_POINTS = 1024
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [1:0]                cmd,
  input  logic [7:0]                glyph_byte,
  input  logic [9:0]                point_index,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [2:0]                status,
  output logic signed [COORD_W-1:0] point_x,
  output logic signed [COORD_W-1:0] point_y,
  output logic                      curve_on,
  output logic                      ends_contour,
  output logic [10:0]               point_count
);

  localparam int AW = $clog2(MAX_POINTS);

  // Memory write controls and addresses from the parser.
  gdec_wr_t           wr;
  logic [AW-1:0]      waddr;
  logic [AW-1:0]      rd_addr;
  logic [FLAG_W-1:0]  flag_wdata;
  logic [COORD_W-1:0] coord_wdata;
  logic [EPOCH_W-1:0] end_wdata;

  // Registered read data for rd_addr, valid in the cycle after it is set.
  logic [FLAG_W-1:0]  flag_rd;
  logic [COORD_W-1:0] x_rd;
  logic [COORD_W-1:0] y_rd;
  logic [EPOCH_W-1:0] end_rd;

  // Parser, sequencer and output register.
  gdec_ctrl #(.MAX_POINTS(MAX_POINTS)) u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .cmd          (cmd),
    .glyph_byte   (glyph_byte),
    .point_index  (point_index),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .status       (status),
    .point_x      (point_x),
    .point_y      (point_y),
    .curve_on     (curve_on),
    .ends_contour (ends_contour),
    .point_count  (point_count),
    .wr           (wr),
    .waddr        (waddr),
    .flag_wdata   (flag_wdata),
    .coord_wdata  (coord_wdata),
    .end_wdata    (end_wdata),
    .rd_addr      (rd_addr),
    .flag_rd      (flag_rd),
    .x_rd         (x_rd),
    .y_rd         (y_rd),
    .end_rd       (end_rd)
  );

  // Flag, X, Y and contour-end memories, one shared read address.
  gdec_mem #(.MAX_POINTS(MAX_POINTS)) u_mem (
    .clk         (clk),
    .wr          (wr),
    .waddr       (waddr),
    .flag_wdata  (flag_wdata),
    .coord_wdata (coord_wdata),
    .end_wdata   (end_wdata),
    .rd_addr     (rd_addr),
    .flag_rd     (flag_rd),
    .x_rd        (x_rd),
    .y_rd        (y_rd),
    .end_rd      (end_rd)
  );

endmodule

FILE: rtl/core/gdec_checker.sv
`include "glyph_outline_decoder_core_assert.svh"

module gdec_checker import gdec_pkg::*; (
  input logic                      clk,
  input logic                      rst,
  input logic                      in_valid,
  input logic                      in_stall,
  input logic [1:0]                cmd,
  input logic [7:0]                glyph_byte,
  input logic [9:0]                point_index,
  input logic                      out_valid,
  input logic                      out_stall,
  input logic [2:0]                status,
  input logic signed [COORD_W-1:0] point_x,
  input logic signed [COORD_W-1:0] point_y,
  input logic                      curve_on,
  input logic                      ends_contour,
  input logic [10:0]               point_count
);

  `GDEC_CHECK_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(status) && $stable(point_x) && $stable(point_count), "stalled result changed")
  `GDEC_CHECK(a_status_code, out_valid, status <= ST_NOPOINT, "status code out of range")
  `GDEC_CHECK(a_zero_fields, out_valid && status != ST_POINT, point_x == 0 && point_y == 0 && !curve_on && !ends_contour, "non-point result carries point fields")
  `GDEC_CHECK(a_error_count, out_valid && (status == ST_COMPOSITE || status == ST_TOOMANY || status == ST_TRUNC), point_count == 0, "error result carries a point count")

endmodule

bind glyph_outline_decoder_core gdec_checker u_gdec_checker (.*);
